// File: design/hdat_pkg.sv
// Shared types and constants for the HDM decoder address translation block.
// No dependencies; imported by every module of the block.
package hdat_pkg;

    localparam int AddrWidth   = 64;
    localparam int CodeWidth   = 3;
    localparam int ModeWidth   = 2;
    localparam int StatusWidth = 2;
    localparam int CfgIdxWidth = 3;
    localparam int ShiftWidth  = 5;

    // Offset bits always kept below the interleave selector.
    localparam logic [ShiftWidth-1:0] LowKeepBits = ShiftWidth'(8);

    // Access kinds
    localparam logic [ModeWidth-1:0] MODE_READ  = 2'd0;
    localparam logic [ModeWidth-1:0] MODE_WRITE = 2'd1;
    localparam logic [ModeWidth-1:0] MODE_CACHE = 2'd2;

    // Result status codes
    localparam logic [StatusWidth-1:0] ST_FORWARD = 2'd0;
    localparam logic [StatusWidth-1:0] ST_ERROR   = 2'd1;
    localparam logic [StatusWidth-1:0] ST_DROPPED = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIdxWidth-1:0] REG_WINDOW_BASE = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_WINDOW_SIZE = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_GRANULARITY = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_WAYS        = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_MEMORY_SIZE = 3'd4;

    typedef struct packed {
        logic [AddrWidth-1:0] window_base;
        logic [AddrWidth-1:0] window_size;
        logic [CodeWidth-1:0] granularity_code;
        logic [CodeWidth-1:0] ways_code;
        logic [AddrWidth-1:0] memory_size;
    } cfg_t;

    // One transaction moving between pipeline stages.
    typedef struct packed {
        logic                 valid;
        logic [ModeWidth-1:0] mode;
        logic                 fail;
        logic [AddrWidth-1:0] addr;
    } stage_t;

endpackage

// File: design/hdat_cfg_regs.sv
// Configuration register file for the address translation block.
// Depends on hdat_pkg.
module hdat_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hdat_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [hdat_pkg::AddrWidth-1:0]   cfg_data,
    output hdat_pkg::cfg_t                cfg
);
    import hdat_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_BASE: cfg_next.window_base      = cfg_data;
                REG_WINDOW_SIZE: cfg_next.window_size      = cfg_data;
                REG_GRANULARITY: cfg_next.granularity_code = cfg_data[CodeWidth-1:0];
                REG_WAYS:        cfg_next.ways_code        = cfg_data[CodeWidth-1:0];
                REG_MEMORY_SIZE: cfg_next.memory_size      = cfg_data;
                default:         cfg_next = cfg_reg; // drop writes to unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// File: design/hdat_window.sv
// Input register and base subtraction: offset into the decoder window.
// Depends on hdat_pkg.
module hdat_window (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [hdat_pkg::ModeWidth-1:0] mode,
    input  logic [hdat_pkg::AddrWidth-1:0] req_addr,
    input  logic [hdat_pkg::AddrWidth-1:0] window_base,
    output hdat_pkg::stage_t               win
);
    import hdat_pkg::*;

    logic                 valid_reg;
    logic [ModeWidth-1:0] mode_reg;
    logic [AddrWidth-1:0] hpa_reg;
    logic [AddrWidth:0]   diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= mode;
            hpa_reg  <= req_addr;
        end
    end

    // Borrow out flags an address below the base.
    assign diff = {1'b0, hpa_reg} - {1'b0, window_base};

    always_comb
    begin
        win.valid = valid_reg;
        win.mode  = mode_reg;
        win.fail  = diff[AddrWidth];
        win.addr  = diff[AddrWidth-1:0];
    end

endmodule

// File: design/hdat_remap.sv
// Window size check and interleave way removal from the offset.
// Depends on hdat_pkg.
module hdat_remap (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hdat_pkg::stage_t               win,
    input  logic [hdat_pkg::AddrWidth-1:0] window_size,
    input  logic [hdat_pkg::CodeWidth-1:0] granularity_code,
    input  logic [hdat_pkg::CodeWidth-1:0] ways_code,
    output hdat_pkg::stage_t               remap
);
    import hdat_pkg::*;

    logic                  valid_reg;
    logic [ModeWidth-1:0]  mode_reg;
    logic                  fail_reg;
    logic [AddrWidth-1:0]  off_reg;
    logic [ShiftWidth-1:0] low_bits;
    logic [ShiftWidth-1:0] high_shift;
    logic [AddrWidth-1:0]  low_mask;
    logic [AddrWidth-1:0]  high_part;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= win.valid;
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= win.mode;
        fail_reg <= win.fail;
        off_reg  <= win.addr;
    end

    assign low_bits   = LowKeepBits + ShiftWidth'(granularity_code);
    assign high_shift = low_bits + ShiftWidth'(ways_code);
    assign low_mask   = (AddrWidth'(1) << low_bits) - AddrWidth'(1);
    assign high_part  = (off_reg >> high_shift) << low_bits;

    always_comb
    begin
        remap.valid = valid_reg;
        remap.mode  = mode_reg;
        remap.fail  = fail_reg | (off_reg >= window_size);
        remap.addr  = (off_reg & low_mask) | high_part;
    end

endmodule

// File: design/hdat_result.sv
// Backing memory bound check and result register.
// Depends on hdat_pkg.
module hdat_result (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hdat_pkg::stage_t                 remap,
    input  logic [hdat_pkg::AddrWidth-1:0]   memory_size,
    output logic                             done,
    output logic [hdat_pkg::StatusWidth-1:0] status,
    output logic [hdat_pkg::AddrWidth-1:0]   device_addr
);
    import hdat_pkg::*;

    logic                   s2_valid_reg;
    logic [ModeWidth-1:0]   s2_mode_reg;
    logic                   s2_fail_reg;
    logic [AddrWidth-1:0]   s2_addr_reg;
    logic                   done_reg;
    logic [StatusWidth-1:0] status_reg;
    logic [StatusWidth-1:0] status_next;
    logic [AddrWidth-1:0]   dpa_reg;
    logic [AddrWidth-1:0]   dpa_next;
    logic                   fail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= remap.valid;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_mode_reg <= remap.mode;
        s2_fail_reg <= remap.fail;
        s2_addr_reg <= remap.addr;
        status_reg  <= status_next;
        dpa_reg     <= dpa_next;
    end

    assign fail = s2_fail_reg | (s2_addr_reg >= memory_size);

    always_comb
    begin
        priority if (!fail)
        begin
            status_next = ST_FORWARD;
            dpa_next    = s2_addr_reg;
        end
        else if (s2_mode_reg == MODE_WRITE)
        begin
            status_next = ST_DROPPED;
            dpa_next    = '0;
        end
        else
        begin
            // read, cache access and the unused fourth kind answer with an error
            status_next = ST_ERROR;
            dpa_next    = '0;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign device_addr = dpa_reg;

endmodule

// File: design/hdm_decoder_address_translate_top.sv
// Top level of the HDM decoder address translation block.
// Depends on hdat_pkg, hdat_cfg_regs, hdat_window, hdat_remap, hdat_result.
//
// Translates one host physical address per clock into a device physical
// address for a single decoder with power-of-two interleave. A transaction
// is taken at every rising edge where start is high; busy is always low, so
// a new transaction may be issued in every cycle. Each transaction yields
// exactly one result, presented for a single cycle with done high, after
// it has passed through the input register, base subtraction into the
// remap register, window check and way removal into the bound register,
// and memory bound check into the result register.
// Results come back in issue order. The receiver cannot stall the block:
// capture status and device_addr in the cycle that done is high. Status
// reads forwarded, error (failed read or cache access, and the unused
// fourth access kind) or dropped (failed write); device_addr is zero unless
// forwarded. A transaction fails when the address is below the window
// base, its offset is at or above the window size, or the translated
// address is at or above memory_size. Program the configuration registers
// through cfg_we/cfg_index/cfg_data only while no transaction is in flight;
// writes take effect at the next edge and writes to an unknown index are
// dropped.
module hdm_decoder_address_translate_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hdat_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  logic [hdat_pkg::AddrWidth-1:0]     cfg_data,
    input  logic                               start,
    output logic                               busy,
    input  logic [hdat_pkg::ModeWidth-1:0]     mode,
    input  logic [hdat_pkg::AddrWidth-1:0]     req_addr,
    output logic                               done,
    output logic [hdat_pkg::StatusWidth-1:0]   status,
    output logic [hdat_pkg::AddrWidth-1:0]     device_addr
);
    import hdat_pkg::*;

    cfg_t   cfg;
    stage_t win;
    stage_t remap;

    // Fully pipelined: never hold off a new transaction.
    assign busy = 1'b0;

    hdat_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Capture the transaction and subtract the window base.
    hdat_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .req_addr    (req_addr),
        .window_base (cfg.window_base),
        .win         (win)
    );

    // Check the window size and drop the interleave way bits.
    hdat_remap u_remap (
        .clk              (clk),
        .rst_n            (rst_n),
        .win              (win),
        .window_size      (cfg.window_size),
        .granularity_code (cfg.granularity_code),
        .ways_code        (cfg.ways_code),
        .remap            (remap)
    );

    // Bound against backing memory and register the result.
    hdat_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .remap       (remap),
        .memory_size (cfg.memory_size),
        .done        (done),
        .status      (status),
        .device_addr (device_addr)
    );

endmodule
